FILE: rtl/arp_fcr_pkg.sv
package arp_fcr_pkg;

	typedef enum logic [1:0] {
		CMD_FRAME = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_INVAL = 2'd2,
		CMD_NONE  = 2'd3
	} command_t;

	localparam logic [1:0] CFG_SPOOF_SOURCE = 2'd0;
	localparam logic [1:0] CFG_SEND_ENABLE  = 2'd1;
	localparam logic [1:0] CFG_OWN_MAC      = 2'd2;

	localparam logic [15:0] MIN_FRAME   = 16'd42;
	localparam logic [15:0] ETH_ARP     = 16'h0806;
	localparam logic [15:0] HW_ETHER    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [7:0]  HW_LEN      = 8'd6;
	localparam logic [7:0]  PROTO_LEN   = 8'd4;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [15:0] OP_REPLY    = 16'd2;

	localparam logic [4:0] ST_TABLE_OP      = 5'd0;
	localparam logic [4:0] ST_SHORT         = 5'd1;
	localparam logic [4:0] ST_NOT_ARP       = 5'd2;
	localparam logic [4:0] ST_BAD_HWTYPE    = 5'd3;
	localparam logic [4:0] ST_BAD_PROTOTYPE = 5'd4;
	localparam logic [4:0] ST_BAD_HWLEN     = 5'd5;
	localparam logic [4:0] ST_BAD_PROTOLEN  = 5'd6;
	localparam logic [4:0] ST_BAD_OPCODE    = 5'd7;
	localparam logic [4:0] ST_REQ_UNBOUND   = 5'd8;
	localparam logic [4:0] ST_REQ_ZERO_MAC  = 5'd9;
	localparam logic [4:0] ST_REQ_ECHO      = 5'd10;
	localparam logic [4:0] ST_REQ_ANSWERED  = 5'd11;
	localparam logic [4:0] ST_RPL_UNBOUND   = 5'd12;
	localparam logic [4:0] ST_RPL_ZERO_MAC  = 5'd13;
	localparam logic [4:0] ST_RPL_FORGED    = 5'd14;
	localparam logic [4:0] ST_RPL_WRONG_SRC = 5'd15;
	localparam logic [4:0] ST_RPL_TGT_UNB   = 5'd16;
	localparam logic [4:0] ST_RPL_TGT_ZERO  = 5'd17;
	localparam logic [4:0] ST_RPL_TGT_WRONG = 5'd18;
	localparam logic [4:0] ST_RPL_VALID     = 5'd19;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  entry_index;
		logic [15:0] frame_length;
		logic [15:0] ether_type;
		logic [47:0] header_word;
		logic [15:0] opcode;
		logic [47:0] eth_src_mac;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [47:0] target_mac;
		logic [31:0] target_ip;
	} item_t;

	typedef struct packed {
		logic [4:0]  status;
		logic        send_reply;
		logic        hwsrc_mismatch;
		logic [47:0] reply_eth_dest;
		logic [47:0] reply_eth_src;
		logic [47:0] reply_sender_mac;
		logic [31:0] reply_sender_ip;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
	} result_t;

endpackage

FILE: rtl/arp_frame_checker_responder.sv
// ARP frame checker and responder. Raise start with an item while busy is low; the item is
// taken at that edge and busy rises. Every item gives exactly one result word, shown on
// result for a single cycle with result_valid high; the receiver cannot stall, so capture it
// then. Table writes and invalidates (command 1 and 2) update the binding table at the
// accept edge and report straight from the check state, as do frames that fail a header check. ARP
// requests and replies search the binding table through one IP comparator that visits
// one entry at a time (a registered table read, then the compare), lowest entry first,
// stopping at the first valid match; at most 16 entries are visited per search. A reply
// takes up to two such searches, sender then target. Only entries 0 to 15 are reachable
// through entry_index. Configuration writes are always accepted (cfg_ready stays high);
// write them only while the block is idle.
module arp_frame_checker_responder #(
	parameter int BINDING_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  arp_fcr_pkg::item_t   item,
	output logic                 result_valid,
	output arp_fcr_pkg::result_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [47:0]          cfg_data
);
	import arp_fcr_pkg::*;

	// entry_index is four bits wide, so no more than sixteen slots can ever hold a binding
	localparam int USED = (BINDING_ENTRIES < 16) ? BINDING_ENTRIES : 16;
	localparam int IW   = (USED > 1) ? $clog2(USED) : 1;
	localparam logic [IW-1:0] LAST = IW'(USED - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_CMP,
		S_EVAL
	} state_t;

	state_t          state_q;
	item_t           item_q;
	result_t         res_q;
	logic            res_valid_q;
	logic [USED-1:0] valid_q;
	logic [IW-1:0]   ptr_q;
	logic [31:0]     key_q;
	logic            phase_q;
	logic            found_q;
	logic [47:0]     bound_q;
	logic            spoof_q;
	logic            send_en_q;
	logic [47:0]     own_mac_q;

	logic [31:0] ip_mem [USED];
	logic [47:0] mac_mem [USED];
	logic [31:0] rd_ip_q;
	logic [47:0] rd_mac_q;

	logic          accept;
	logic          in_range;
	logic          tbl_we;
	logic [IW-1:0] waddr;
	logic          hit;
	logic          fin;
	logic          go_scan;
	logic [31:0]   scan_key;
	result_t       res_d;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_range  = (32'(item.entry_index) < 32'(USED));
	assign tbl_we    = accept && (item.command == CMD_WRITE) && in_range;
	assign waddr     = item.entry_index[IW-1:0];
	assign hit       = valid_q[ptr_q] && (rd_ip_q == key_q);

	// binding store: written at accept, read one entry at a time, registered, during the search
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			ip_mem[waddr]  <= item.target_ip;
			mac_mem[waddr] <= item.target_mac;
		end
		rd_ip_q  <= ip_mem[ptr_q];
		rd_mac_q <= mac_mem[ptr_q];
	end

	// header checks, and the verdict once a search has finished
	always_comb begin
		res_d    = '0;
		fin      = 1'b0;
		go_scan  = 1'b0;
		scan_key = '0;
		case (state_q)
			S_CHECK: begin
				if (item_q.command != CMD_FRAME) begin
					fin          = 1'b1;
					res_d.status = ST_TABLE_OP;
				end else if (item_q.frame_length < MIN_FRAME) begin
					fin          = 1'b1;
					res_d.status = ST_SHORT;
				end else if (item_q.ether_type != ETH_ARP) begin
					fin          = 1'b1;
					res_d.status = ST_NOT_ARP;
				end else if (item_q.header_word[47:32] != HW_ETHER) begin
					fin          = 1'b1;
					res_d.status = ST_BAD_HWTYPE;
				end else if (item_q.header_word[31:16] != PROTO_IPV4) begin
					fin          = 1'b1;
					res_d.status = ST_BAD_PROTOTYPE;
				end else if (item_q.header_word[15:8] != HW_LEN) begin
					fin          = 1'b1;
					res_d.status = ST_BAD_HWLEN;
				end else if (item_q.header_word[7:0] != PROTO_LEN) begin
					fin          = 1'b1;
					res_d.status = ST_BAD_PROTOLEN;
				end else if (item_q.opcode == OP_REQUEST) begin
					go_scan  = 1'b1;
					scan_key = item_q.target_ip;
				end else if (item_q.opcode == OP_REPLY) begin
					go_scan  = 1'b1;
					scan_key = item_q.sender_ip;
				end else begin
					fin                  = 1'b1;
					res_d.status         = ST_BAD_OPCODE;
					res_d.hwsrc_mismatch = (item_q.eth_src_mac != item_q.sender_mac);
				end
			end
			S_EVAL: begin
				fin                  = 1'b1;
				res_d.hwsrc_mismatch = (item_q.eth_src_mac != item_q.sender_mac);
				if (item_q.opcode == OP_REQUEST) begin
					if (!found_q) begin
						res_d.status = ST_REQ_UNBOUND;
					end else if (bound_q == '0) begin
						res_d.status = ST_REQ_ZERO_MAC;
					end else begin
						res_d.reply_eth_dest   = item_q.eth_src_mac;
						res_d.reply_eth_src    = spoof_q ? bound_q : own_mac_q;
						res_d.reply_sender_mac = bound_q;
						res_d.reply_sender_ip  = item_q.target_ip;
						res_d.reply_target_mac = item_q.sender_mac;
						res_d.reply_target_ip  = item_q.sender_ip;
						if (item_q.eth_src_mac == bound_q) begin
							res_d.status = ST_REQ_ECHO;
						end else begin
							res_d.status     = ST_REQ_ANSWERED;
							res_d.send_reply = send_en_q;
						end
					end
				end else if (!phase_q) begin
					if (!found_q) begin
						res_d.status = ST_RPL_UNBOUND;
					end else if (bound_q == '0) begin
						res_d.status = ST_RPL_ZERO_MAC;
					end else if (bound_q != item_q.sender_mac) begin
						res_d.status = ST_RPL_FORGED;
					end else if (item_q.sender_mac != item_q.eth_src_mac) begin
						res_d.status = ST_RPL_WRONG_SRC;
					end else begin
						// sender checks out: search again for the target
						fin      = 1'b0;
						go_scan  = 1'b1;
						scan_key = item_q.target_ip;
					end
				end else begin
					if (!found_q) begin
						res_d.status = ST_RPL_TGT_UNB;
					end else if (bound_q == '0) begin
						res_d.status = ST_RPL_TGT_ZERO;
					end else if (bound_q != item_q.target_mac) begin
						res_d.status = ST_RPL_TGT_WRONG;
					end else begin
						res_d.status = ST_RPL_VALID;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			valid_q     <= '0;
			ptr_q       <= '0;
			key_q       <= '0;
			phase_q     <= 1'b0;
			found_q     <= 1'b0;
			bound_q     <= '0;
			spoof_q     <= 1'b0;
			send_en_q   <= 1'b1;
			own_mac_q   <= '0;
		end else begin
			res_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPOOF_SOURCE: spoof_q   <= cfg_data[0];
					CFG_SEND_ENABLE:  send_en_q <= cfg_data[0];
					CFG_OWN_MAC:      own_mac_q <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q  <= item;
						state_q <= S_CHECK;
						if (in_range) begin
							if (item.command == CMD_WRITE) begin
								valid_q[waddr] <= 1'b1;
							end else if (item.command == CMD_INVAL) begin
								valid_q[waddr] <= 1'b0;
							end
						end
					end
				end
				S_CHECK, S_EVAL: begin
					if (fin) begin
						res_q       <= res_d;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (go_scan) begin
						key_q   <= scan_key;
						ptr_q   <= '0;
						phase_q <= (state_q == S_EVAL);
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					// stop at the first valid match, or after the last slot
					if (hit || (ptr_q == LAST)) begin
						found_q <= hit;
						bound_q <= rd_mac_q;
						state_q <= S_EVAL;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |=> !res_valid_q)
		else $error("result strobe held for more than one cycle");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !busy)
		else $error("result shown while still busy");

	a_send_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.send_reply) |-> (res_q.status == ST_REQ_ANSWERED))
		else $error("send_reply raised without an answered request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy did not rise after an accepted word");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (ptr_q <= LAST))
		else $error("search pointer beyond the last slot");
`endif

endmodule
